FILE: design/fvwo_pkg.sv
// Shared types and constants of the four-voice wavetable oscillator mixer.
package fvwo_pkg;

  // Voice count and field widths
  localparam int VOICES         = 4;
  localparam int VOICE_BITS     = 2;
  localparam int ELEMENT_BITS   = 2;
  localparam int ADDRESS_BITS   = 8;
  localparam int VALUE_BITS     = 12;
  localparam int LEVEL_BITS     = 13;
  localparam int OUT_BITS       = 12;
  localparam int STEP_BITS      = 16;
  localparam int OFFSET_BITS    = 8;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 16;

  // Register map
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_BASE   = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_BASE = 4'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT       = 4'd8;

  // Command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // Per-voice configuration
  typedef struct packed {
    logic [VOICES-1:0][STEP_BITS-1:0]   step;
    logic [VOICES-1:0][OFFSET_BITS-1:0] offset;
  } cfg_t;

endpackage

FILE: design/fvwo_ifs.sv
// Channel interfaces: input items, result words and configuration writes.
interface fvwo_item_if;
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic [fvwo_pkg::ELEMENT_BITS-1:0] table_element;
  logic [fvwo_pkg::ADDRESS_BITS-1:0] table_address;
  logic [fvwo_pkg::VALUE_BITS-1:0]   table_value;
  logic [fvwo_pkg::LEVEL_BITS-1:0]   master_level;
  logic [fvwo_pkg::LEVEL_BITS-1:0]   level_0;
  logic [fvwo_pkg::LEVEL_BITS-1:0]   level_1;
  logic [fvwo_pkg::LEVEL_BITS-1:0]   level_2;
  logic [fvwo_pkg::LEVEL_BITS-1:0]   level_3;

  modport source (output valid, command, table_element, table_address, table_value,
                  master_level, level_0, level_1, level_2, level_3, input ready);
  modport sink (input valid, command, table_element, table_address, table_value,
                master_level, level_0, level_1, level_2, level_3, output ready);
endinterface

interface fvwo_sample_if;
  logic                          valid;
  logic                          ready;
  logic [fvwo_pkg::OUT_BITS-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface

interface fvwo_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [fvwo_pkg::CFG_INDEX_BITS-1:0] index;
  logic [fvwo_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/fvwo_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module fvwo_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/fvwo_cfg.sv
// Configuration register file: per-voice phase steps and table offsets.
module fvwo_cfg (
  input  logic              clk,
  input  logic              rst,
  fvwo_cfg_if.sink          cfg_ch,
  output fvwo_pkg::cfg_t    cfg
);

  fvwo_pkg::cfg_t regs;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = regs;

  // Decode the index and store the word; drop writes beyond the map
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index < fvwo_pkg::REG_OFFSET_BASE) begin
        regs.step[cfg_ch.index[fvwo_pkg::VOICE_BITS-1:0]] <= cfg_ch.data;
      end else if (cfg_ch.index < fvwo_pkg::REG_COUNT) begin
        regs.offset[cfg_ch.index[fvwo_pkg::VOICE_BITS-1:0]] <=
          cfg_ch.data[fvwo_pkg::OFFSET_BITS-1:0];
      end
    end
  end

endmodule

FILE: design/fvwo_core.sv
// Oscillator core: table and phase memories, voice pipeline, mixer and output word.
module fvwo_core #(
  parameter int TABLE_ADDR_BITS = 8,
  parameter int PHASE_FRAC_BITS = 14,
  parameter int SAMPLE_BITS     = 12
) (
  input  logic           clk,
  input  logic           rst,
  input  fvwo_pkg::cfg_t cfg,
  fvwo_item_if.sink      in_ch,
  fvwo_sample_if.source  out_ch
);

  localparam int VB     = fvwo_pkg::VOICE_BITS;
  localparam int LB     = fvwo_pkg::LEVEL_BITS;
  localparam int ACC_W  = TABLE_ADDR_BITS + PHASE_FRAC_BITS;
  localparam int WADDR  = VB + TABLE_ADDR_BITS;
  localparam int WDEPTH = fvwo_pkg::VOICES << TABLE_ADDR_BITS;
  localparam int FIN_W  = 2 * LB;
  localparam int PROD_W = SAMPLE_BITS + LB;

  fvwo_pkg::state_t state, state_next;

  logic in_ready, tick_start, table_we, out_load;

  // Tick operands
  logic [fvwo_pkg::VOICES-1:0][LB-1:0] lvl;
  logic [LB-1:0]                       master;

  // Voice pipeline
  logic [VB:0]   issue_cnt;
  logic          issue;
  logic          s1_v, s2_v, s3_v, s4_v;
  logic [VB-1:0] s1_voice, s2_voice, s3_voice;
  logic [LB-1:0] scaled;
  logic [LB-1:0] mix, mix_next;
  logic          seen, seen_next;
  logic [FIN_W-1:0] fin;

  // Phase memory with valid bits
  logic [fvwo_pkg::VOICES-1:0] pvalid;
  logic [ACC_W-1:0]            ph_rdata, acc_cur, acc_new;

  // Wave memory
  logic [WADDR-1:0]       w_waddr, w_raddr;
  logic [SAMPLE_BITS-1:0] w_wdata, w_rdata;
  logic [TABLE_ADDR_BITS-1:0] idx;
  logic [PROD_W-1:0]      prod;

  // Output word
  logic                        out_valid;
  logic [fvwo_pkg::OUT_BITS-1:0] out_data;
  logic [FIN_W-1:0]            shifted;
  logic [SAMPLE_BITS-1:0]      satv;

  // Next state and handshake controls
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    tick_start = 1'b0;
    table_we   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      fvwo_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.command == fvwo_pkg::CMD_WRITE) begin
            table_we = 1'b1;
          end else begin
            tick_start = 1'b1;
            state_next = fvwo_pkg::ST_RUN;
          end
        end
      end
      fvwo_pkg::ST_RUN: begin
        if (s4_v) begin
          state_next = fvwo_pkg::ST_DRAIN;
        end
      end
      fvwo_pkg::ST_DRAIN: begin
        if (!out_valid || out_ch.ready) begin
          out_load   = 1'b1;
          state_next = fvwo_pkg::ST_IDLE;
        end
      end
      default: state_next = fvwo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fvwo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ch.ready = in_ready;

  // Issue one voice a cycle while the tick runs
  assign issue = (state == fvwo_pkg::ST_RUN) &&
                 (issue_cnt < (VB + 1)'(fvwo_pkg::VOICES));

  // Advance the accumulator and form the table index
  assign acc_cur = pvalid[s1_voice] ? ph_rdata : '0;
  assign acc_new = acc_cur + ACC_W'(cfg.step[s1_voice]);
  assign idx     = acc_cur[ACC_W-1 -: TABLE_ADDR_BITS] +
                   TABLE_ADDR_BITS'(cfg.offset[s1_voice]);

  // Table addresses and write word
  assign w_waddr = {in_ch.table_element, TABLE_ADDR_BITS'(in_ch.table_address)};
  assign w_wdata = SAMPLE_BITS'(in_ch.table_value);
  assign w_raddr = {s1_voice, idx};

  // Scale by the voice level
  assign prod = w_rdata * lvl[s2_voice];

  // Mix the scaled voice into the running sum
  always_comb begin
    mix_next  = mix;
    seen_next = seen;
    if (s3_voice == '0) begin
      mix_next  = scaled;
      seen_next = (lvl[s3_voice] != '0);
    end else if (lvl[s3_voice] != '0) begin
      mix_next  = seen ? ((mix >> 1) + (scaled >> 1)) : scaled;
      seen_next = 1'b1;
    end
  end

  // Master scaling with saturation
  assign shifted = fin >> SAMPLE_BITS;
  assign satv    = (|shifted[FIN_W-1:SAMPLE_BITS]) ? '1 : shifted[SAMPLE_BITS-1:0];

  fvwo_ram #(
    .WIDTH (ACC_W),
    .DEPTH (fvwo_pkg::VOICES)
  ) u_phase_ram (
    .clk   (clk),
    .we    (s1_v),
    .waddr (s1_voice),
    .wdata (acc_new),
    .raddr (issue_cnt[VB-1:0]),
    .rdata (ph_rdata)
  );

  fvwo_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WDEPTH)
  ) u_wave_ram (
    .clk   (clk),
    .we    (table_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      pvalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (tick_start) begin
        issue_cnt <= '0;
      end else if (issue) begin
        issue_cnt <= issue_cnt + 1'b1;
      end
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v && (s3_voice == VB'(fvwo_pkg::VOICES - 1));
      if (s1_v) begin
        pvalid[s1_voice] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (tick_start) begin
      master <= in_ch.master_level;
      lvl[0] <= in_ch.level_0;
      lvl[1] <= in_ch.level_1;
      lvl[2] <= in_ch.level_2;
      lvl[3] <= in_ch.level_3;
    end
    s1_voice <= issue_cnt[VB-1:0];
    s2_voice <= s1_voice;
    s3_voice <= s2_voice;
    if (s2_v) begin
      scaled <= prod[PROD_W-1:SAMPLE_BITS];
    end
    if (s3_v) begin
      mix  <= mix_next;
      seen <= seen_next;
    end
    if (s4_v) begin
      fin <= mix * master;
    end
    if (out_load) begin
      out_data <= fvwo_pkg::OUT_BITS'(satv);
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_data;

endmodule

FILE: design/four_voice_wavetable_oscillator_mixer.sv
// Top level of the four-voice wavetable oscillator mixer.
//
//   channel  role    payload
//   in_ch    sink    command, table_element, table_address, table_value,
//                    master_level, level_0..level_3
//   out_ch   source  sample_out
//   cfg_ch   sink    index, data (steps at 0..3, offsets at 4..7)
//
// A table write gives no word. A tick runs its four voices
// through one pipeline over the shared phase memory, table memory read port and
// level multiplier: the result word is registered once the last voice is mixed and
// master-scaled, and no further item is taken until then.
// Reset (rst, synchronous) clears the accumulators, registers and control; the
// wave tables hold nothing until written. A stalled result word holds while a
// further item is accepted; a tick then waits at its end for the word to leave.
module four_voice_wavetable_oscillator_mixer #(
  parameter int TABLE_ADDR_BITS = 8,
  parameter int PHASE_FRAC_BITS = 14,
  parameter int SAMPLE_BITS     = 12
) (
  input  logic          clk,
  input  logic          rst,
  fvwo_item_if.sink     in_ch,
  fvwo_sample_if.source out_ch,
  fvwo_cfg_if.sink      cfg_ch
);

  fvwo_pkg::cfg_t cfg;

  fvwo_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  fvwo_core #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

FILE: verif/tb_four_voice_wavetable_oscillator_mixer.sv
// Testbench for the four-voice wavetable oscillator mixer: random and directed words.
`timescale 1ns / 100ps

module tb_four_voice_wavetable_oscillator_mixer;
  import fvwo_pkg::*;

  // One input word as it travels on in_ch
  typedef struct packed {
    logic                    command;
    logic [ELEMENT_BITS-1:0] table_element;
    logic [ADDRESS_BITS-1:0] table_address;
    logic [VALUE_BITS-1:0]   table_value;
    logic [LEVEL_BITS-1:0]   master_level;
    logic [LEVEL_BITS-1:0]   level_0;
    logic [LEVEL_BITS-1:0]   level_1;
    logic [LEVEL_BITS-1:0]   level_2;
    logic [LEVEL_BITS-1:0]   level_3;
  } item_t;

  // Mirror of the oscillator state; holds the samples still owed by the block
  class osc_scoreboard;
    logic [VALUE_BITS-1:0]   wave [VOICES][256];
    bit                      written [VOICES][256];
    logic [21:0]             acc [VOICES];
    logic [STEP_BITS-1:0]    step [VOICES];
    logic [OFFSET_BITS-1:0]  offset [VOICES];
    logic [OUT_BITS-1:0]     samples_due [$];
    int                      errors;

    function new();
      for (int v = 0; v < VOICES; v++) begin
        acc[v] = '0;
        step[v] = '0;
        offset[v] = '0;
        for (int a = 0; a < 256; a++) written[v][a] = 1'b0;
      end
      errors = 0;
    endfunction

    // Register writes beyond the offsets are dropped
    function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx < REG_OFFSET_BASE) step[VOICE_BITS'(idx - REG_STEP_BASE)] = data;
      else if (idx < REG_COUNT) offset[VOICE_BITS'(idx - REG_OFFSET_BASE)] = data[OFFSET_BITS-1:0];
    endfunction

    // Table entry the next tick reads for voice v
    function logic [7:0] read_index(int v);
      logic [7:0] idx;
      idx = acc[v][21:14] + offset[v];
      return idx;
    endfunction

    function int pending();
      return samples_due.size();
    endfunction

    // Advance the mirror by one accepted word
    function void note_item(item_t it);
      logic [LEVEL_BITS-1:0] lvl [VOICES];
      logic [12:0]           scaled [VOICES];
      logic [24:0]           prod;
      logic [12:0]           mix;
      logic [25:0]           mixed_full;
      logic [7:0]            idx;
      bit                    seen;
      if (it.command == CMD_WRITE) begin
        wave[it.table_element][it.table_address] = it.table_value;
        written[it.table_element][it.table_address] = 1'b1;
        return;
      end
      lvl[0] = it.level_0;
      lvl[1] = it.level_1;
      lvl[2] = it.level_2;
      lvl[3] = it.level_3;
      // Read, scale and advance every voice
      for (int v = 0; v < VOICES; v++) begin
        idx = read_index(v);
        prod = wave[v][idx] * lvl[v];
        scaled[v] = prod[24:12];
        acc[v] = acc[v] + {6'd0, step[v]};
      end
      // First live voice replaces the sum, later ones average in
      mix = scaled[0];
      seen = lvl[0] != 0;
      for (int v = 1; v < VOICES; v++) begin
        if (lvl[v] != 0) begin
          mix = seen ? (mix >> 1) + (scaled[v] >> 1) : scaled[v];
          seen = 1'b1;
        end
      end
      // Master scaling with saturation
      mixed_full = mix * it.master_level;
      samples_due.push_back(mixed_full[25:12] > 14'd4095 ? 12'hFFF : mixed_full[23:12]);
    endfunction

    // Compare one result word with the oldest sample owed
    function void check_sample(logic [OUT_BITS-1:0] got);
      logic [OUT_BITS-1:0] want;
      if (samples_due.size() == 0) begin
        $error("sample_out: no sample expected, actual %0d", got);
        errors++;
        return;
      end
      want = samples_due.pop_front();
      if (got !== want) begin
        $error("sample_out: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   steady;
  int   items_sent;
  osc_scoreboard sb;

  fvwo_item_if   in_ch ();
  fvwo_sample_if out_ch ();
  fvwo_cfg_if    cfg_ch ();

  four_voice_wavetable_oscillator_mixer DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
  endfunction

  function logic [VALUE_BITS-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 12'd0;
      1: return 12'd4095;
      default: return VALUE_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  function logic [LEVEL_BITS-1:0] rand_level();
    case ($urandom_range(0, 9))
      0, 1: return 13'd0;
      2: return 13'd4096;
      3: return 13'd8191;
      4: return LEVEL_BITS'($urandom_range(0, 8191));
      default: return LEVEL_BITS'($urandom_range(1, 4096));
    endcase
  endfunction

  function item_t rand_item();
    item_t it;
    it.command       = ($urandom_range(0, 9) < 3) ? CMD_WRITE : CMD_TICK;
    it.table_element = ELEMENT_BITS'($urandom_range(0, 3));
    it.table_address = ADDRESS_BITS'($urandom_range(0, 255));
    it.table_value   = rand_value();
    it.master_level  = rand_level();
    it.level_0       = rand_level();
    it.level_1       = rand_level();
    it.level_2       = rand_level();
    it.level_3       = rand_level();
    return it;
  endfunction

  function item_t make_write(int e, int a, int v);
    item_t it;
    it = rand_item();
    it.command       = CMD_WRITE;
    it.table_element = ELEMENT_BITS'(e);
    it.table_address = ADDRESS_BITS'(a);
    it.table_value   = VALUE_BITS'(v);
    return it;
  endfunction

  function item_t make_tick(int m, int l0, int l1, int l2, int l3);
    item_t it;
    it = rand_item();
    it.command      = CMD_TICK;
    it.master_level = LEVEL_BITS'(m);
    it.level_0      = LEVEL_BITS'(l0);
    it.level_1      = LEVEL_BITS'(l1);
    it.level_2      = LEVEL_BITS'(l2);
    it.level_3      = LEVEL_BITS'(l3);
    return it;
  endfunction

  // Offer one word, wait for its handshake, then note it; valid stays high
  task send_item(item_t it);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.command       <= it.command;
    in_ch.table_element <= it.table_element;
    in_ch.table_address <= it.table_address;
    in_ch.table_value   <= it.table_value;
    in_ch.master_level  <= it.master_level;
    in_ch.level_0       <= it.level_0;
    in_ch.level_1       <= it.level_1;
    in_ch.level_2       <= it.level_2;
    in_ch.level_3       <= it.level_3;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
    items_sent++;
  endtask

  // Fill any table entry the tick would read before sending it
  task send_safe(item_t it);
    logic [7:0] idx;
    if (it.command == CMD_TICK) begin
      for (int v = 0; v < VOICES; v++) begin
        idx = sb.read_index(v);
        if (!sb.written[v][idx]) send_item(make_write(v, int'(idx), int'(rand_value())));
      end
    end
    send_item(it);
  endtask

  task write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, data);
  endtask

  // Drop valid and hold off until every sample has left, then let the pipe settle
  task drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task configure(int phase);
    logic [STEP_BITS-1:0]   st;
    logic [OFFSET_BITS-1:0] off;
    for (int v = 0; v < VOICES; v++) begin
      case (phase)
        0: begin
          st = 16'hFFFF;
          off = 8'hFF;
        end
        1: begin
          st = 16'd0;
          off = 8'd0;
        end
        default: begin
          st = STEP_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 4096));
          off = OFFSET_BITS'($urandom_range(0, 255));
        end
      endcase
      write_reg(REG_STEP_BASE + CFG_INDEX_BITS'(v), st);
      write_reg(REG_OFFSET_BASE + CFG_INDEX_BITS'(v), off);
    end
    // Writes past the register map must be ignored
    write_reg(CFG_INDEX_BITS'((phase == 0) ? 15 : $urandom_range(REG_COUNT, 15)),
              CFG_DATA_BITS'((phase == 0) ? 65535 : $urandom_range(0, 65535)));
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side: check accepted words and stall at random
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) sb.check_sample(out_ch.sample_out);
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!steady && $urandom_range(0, 4) == 0) hold = pick_gap();
      end
    end
  end

  initial begin
    int phase_start;
    sb = new();
    steady = 1'b0;
    items_sent = 0;
    phase_start = 0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_TICK;
    in_ch.table_element = '0;
    in_ch.table_address = '0;
    in_ch.table_value = '0;
    in_ch.master_level = '0;
    in_ch.level_0 = '0;
    in_ch.level_1 = '0;
    in_ch.level_2 = '0;
    in_ch.level_3 = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words with reset registers: every tick reads entry zero
    send_safe(make_write(0, 0, 4095));
    send_safe(make_write(1, 0, 0));
    send_safe(make_write(2, 0, 2048));
    send_safe(make_write(3, 0, 1));
    send_safe(make_write(3, 255, 4095));
    send_safe(make_write(0, 255, 0));
    send_safe(make_tick(4096, 0, 0, 0, 0));          // all voices muted
    send_safe(make_tick(4096, 4096, 0, 0, 0));       // single voice at unity
    send_safe(make_tick(4096, 0, 0, 4096, 0));       // later voice replaces the sum
    send_safe(make_tick(4096, 4096, 4096, 4096, 4096));
    send_safe(make_tick(8191, 8191, 0, 0, 0));       // above unity, saturates
    send_safe(make_tick(8191, 8191, 8191, 8191, 8191));
    send_safe(make_tick(0, 4096, 4096, 4096, 4096)); // master muted
    send_safe(make_tick(4096, 0, 0, 0, 4096));
    send_safe(make_tick(4096, 0, 4096, 0, 0));
    send_safe(make_tick(8191, 1, 1, 1, 1));
    send_safe(make_write(1, 0, 4095));
    send_safe(make_tick(4096, 0, 8191, 0, 8191));

    // Random phases, each under its own register setting; fill writes count too
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      configure(phase);
      steady = (phase == 2);
      phase_start = items_sent;
      while (items_sent - phase_start < 322) send_safe(rand_item());
    end
    steady = 1'b0;

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** four_voice_wavetable_oscillator_mixer: PASSED **");
    end else begin
      $display("** four_voice_wavetable_oscillator_mixer: FAILED **");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #4_000_000;
    $display("** four_voice_wavetable_oscillator_mixer: FAILED **");
    $finish;
  end

endmodule
